// ===== design/ssm_pkg.sv =====
// Package for scaled_softmax: types, constants, exponential tables.
package ssm_pkg;

   localparam int DefaultMaxKeys = 4;
   localparam int ScaleW   = 17;
   localparam int ScoreW   = 16;
   localparam int WeightW  = 17;
   localparam int ExpW     = 17;
   localparam int SumW     = 24;
   localparam logic [ScaleW-1:0] ScaleOne = 17'd65536;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_EXP_RD,
      ST_EXP_MUL1,
      ST_EXP_MUL2,
      ST_DIV_RD,
      ST_DIV,
      ST_DIV_RUN,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic store_score;   // write scaled score, update max
      logic clear_vec;     // restart the vector
      logic set_drop;
      logic exp_start;     // latch table products stage 1
      logic exp_finish;    // finish stage 2 and accumulate
      logic div_start;
      logic rsp_load;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
   } stat_type;

   function automatic logic [16:0] exp_int(input logic [3:0] i);
      logic [16:0] r;
      begin
         case (i)
            4'd0: r = 17'd65536;  4'd1: r = 17'd24109; 4'd2: r = 17'd8869;
            4'd3: r = 17'd3263;   4'd4: r = 17'd1200;  4'd5: r = 17'd442;
            4'd6: r = 17'd162;    4'd7: r = 17'd60;    4'd8: r = 17'd22;
            4'd9: r = 17'd8;      4'd10: r = 17'd3;    4'd11: r = 17'd1;
            default: r = 17'd0;
         endcase
         return r;
      end
   endfunction

   function automatic logic [16:0] exp_hi(input logic [3:0] h);
      logic [16:0] r;
      begin
         case (h)
            4'd0: r = 17'd65536;  4'd1: r = 17'd61565; 4'd2: r = 17'd57835;
            4'd3: r = 17'd54331;  4'd4: r = 17'd51039; 4'd5: r = 17'd47947;
            4'd6: r = 17'd45042;  4'd7: r = 17'd42313; 4'd8: r = 17'd39750;
            4'd9: r = 17'd37341;  4'd10: r = 17'd35079; 4'd11: r = 17'd32954;
            4'd12: r = 17'd30957; 4'd13: r = 17'd29081; 4'd14: r = 17'd27319;
            default: r = 17'd25664;
         endcase
         return r;
      end
   endfunction

   function automatic logic [16:0] exp_lo(input logic [3:0] l);
      logic [16:0] r;
      begin
         case (l)
            4'd0: r = 17'd65536;  4'd1: r = 17'd65280; 4'd2: r = 17'd65026;
            4'd3: r = 17'd64772;  4'd4: r = 17'd64520; 4'd5: r = 17'd64268;
            4'd6: r = 17'd64018;  4'd7: r = 17'd63768; 4'd8: r = 17'd63520;
            4'd9: r = 17'd63272;  4'd10: r = 17'd63025; 4'd11: r = 17'd62780;
            4'd12: r = 17'd62535; 4'd13: r = 17'd62291; 4'd14: r = 17'd62048;
            default: r = 17'd61806;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== design/ssm_ram.sv =====
// Generic single-port-write RAM with registered read.
module ssm_ram #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/ssm_divider.sv =====
// Restoring divider: quotient of (exp*65536 + sum/2) / sum, one bit per cycle.
module ssm_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ssm_pkg::ExpW-1:0]   numer,
   input  logic [ssm_pkg::SumW-1:0]   denom,
   output logic                       done,
   output logic [ssm_pkg::WeightW-1:0] quot
);
   import ssm_pkg::*;

   localparam int NumW = ExpW + 16;   // 33 bits
   localparam int CntW = $clog2(NumW + 1);

   logic [NumW-1:0]  num_ff, num_in;
   logic [SumW:0]    rem_ff, rem_in;
   logic [NumW-1:0]  q_ff, q_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SumW:0]    trial;
   logic [NumW-1:0]  dividend;

   assign dividend = {numer, 16'd0} + NumW'(denom >> 1);
   assign trial = {rem_ff[SumW-1:0], num_ff[NumW-1]};

   // one quotient bit per cycle
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CntW'(NumW);
         busy_in = (denom != '0);
         done_in = (denom == '0);
      end else if (busy_ff) begin
         num_in = {num_ff[NumW-2:0], 1'b0};
         if (trial >= {1'b0, denom}) begin
            rem_in = trial - {1'b0, denom};
            q_in   = {q_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff[WeightW-1:0];
endmodule

// ===== design/ssm_datapath.sv =====
// Datapath: scaling, score store, running max, exponential, sum, divide.
module ssm_datapath #(
   parameter int MaxKeys = ssm_pkg::DefaultMaxKeys
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ssm_pkg::ctrl_type            ctrl,
   input  logic [$clog2(MaxKeys)-1:0]   wr_idx,
   input  logic [$clog2(MaxKeys)-1:0]   rd_idx,
   input  logic signed [ssm_pkg::ScoreW-1:0] score,
   input  logic [ssm_pkg::ScaleW-1:0]   scale,
   output ssm_pkg::stat_type            stat,
   output logic [ssm_pkg::WeightW-1:0]  weight,
   output logic                         dropped
);
   import ssm_pkg::*;

   logic signed [ScoreW+ScaleW:0] prod;
   logic signed [ScoreW-1:0]      scaled;
   logic [ScaleW-1:0]             rd_data;
   logic signed [ScoreW-1:0]      max_ff, max_in;
   logic [SumW-1:0]               sum_ff, sum_in;
   logic                          drop_ff, drop_in;
   logic [15:0]                   e;
   logic [16:0]                   p1_ff;
   logic [33:0]                   p2;
   logic [3:0]                    lo_ff;
   logic [ExpW-1:0]               ex_val;
   logic [16:0]                   t_int;
   logic                          zero_ff;
   logic                          div_done;
   logic [WeightW-1:0]            quot;

   // round-half-up scaling: floor((s*scale + 32768) / 65536)
   assign prod   = $signed(score) * $signed({1'b0, scale}) + 34'sd32768;
   assign scaled = prod[ScoreW+15:16];

   ssm_ram #(.Width(ScaleW), .Depth(MaxKeys)) u_store (
      .clock   (clock),
      .wr_en   (ctrl.store_score),
      .wr_addr (wr_idx),
      .wr_data ({scaled[ScoreW-1], scaled}),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   // exponent argument from the stored score
   assign e = 16'(max_ff - $signed(rd_data[ScoreW-1:0]));
   assign t_int = exp_int(e[15:12] != 4'd0 ? 4'd15 : e[11:8]);
   assign p2 = 34'(p1_ff) * 34'(exp_lo(lo_ff)) + 34'd32768;
   assign ex_val = zero_ff ? '0 : p2[32:16];

   // vector state
   always_comb begin
      max_in  = max_ff;
      sum_in  = sum_ff;
      drop_in = drop_ff;
      if (ctrl.clear_vec) begin
         max_in  = -16'sd32768;
         sum_in  = '0;
         drop_in = 1'b0;
      end else begin
         if (ctrl.store_score && scaled > max_ff) max_in = scaled;
         if (ctrl.set_drop) drop_in = 1'b1;
         if (ctrl.exp_finish) sum_in = sum_ff + SumW'(ex_val);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= -16'sd32768;
         sum_ff  <= '0;
         drop_ff <= 1'b0;
      end else begin
         max_ff  <= max_in;
         sum_ff  <= sum_in;
         drop_ff <= drop_in;
      end
      // first table product, rounded
      if (ctrl.exp_start) begin
         p1_ff   <= 17'((34'(t_int) * 34'(exp_hi(e[7:4])) + 34'd32768) >> 16);
         lo_ff   <= e[3:0];
         zero_ff <= (e[15:8] >= 8'd12);
      end
   end

   // exponent cache so divide pass needs no recompute
   logic [ExpW-1:0] ex_mem_rd;
   ssm_ram #(.Width(ExpW), .Depth(MaxKeys)) u_exps (
      .clock   (clock),
      .wr_en   (ctrl.exp_finish),
      .wr_addr (rd_idx),
      .wr_data (ex_val),
      .rd_addr (rd_idx),
      .rd_data (ex_mem_rd)
   );

   ssm_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .numer (ex_mem_rd),
      .denom (sum_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign stat.div_done = div_done;
   assign weight  = (sum_ff == '0) ? '0 : quot;
   assign dropped = drop_ff;

`ifndef SYNTH
   // sum never wraps: each exp is at most 1.0
   a_sum_grow: assert property (@(posedge clock) disable iff (reset)
      ctrl.exp_finish && !ctrl.clear_vec |=> sum_ff >= $past(sum_ff))
      else $error("exp sum decreased");
   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.exp_finish |-> ex_val <= ExpW'(65536))
      else $error("exp above one");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear_vec |=> sum_ff == '0 && !drop_ff)
      else $error("clear failed");
`endif
endmodule

// ===== design/ssm_ctrl.sv =====
// Controller: load, exponent pass, divide pass and emit sequencing.
module ssm_ctrl #(
   parameter int MaxKeys = ssm_pkg::DefaultMaxKeys
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_in_last,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_out_last,
   output ssm_pkg::ctrl_type           ctrl,
   input  ssm_pkg::stat_type           stat,
   output logic [$clog2(MaxKeys)-1:0]  wr_idx,
   output logic [$clog2(MaxKeys)-1:0]  rd_idx
);
   import ssm_pkg::*;

   localparam int IdxW = $clog2(MaxKeys);
   localparam int CntW = $clog2(MaxKeys + 1);

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic            vld_ff, vld_in;
   logic            acc;
   logic            full;
   logic            last_key;

   assign full     = (cnt_ff == CntW'(MaxKeys));
   assign acc      = req_valid && !req_stall;
   assign last_key = (CntW'(idx_ff) + 1'b1 == cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:     if (acc && req_in_last) state_in = ST_EXP_RD;
         ST_EXP_RD:   state_in = ST_EXP_MUL1;
         ST_EXP_MUL1: state_in = ST_EXP_MUL2;
         ST_EXP_MUL2: state_in = last_key ? ST_DIV_RD : ST_EXP_RD;
         ST_DIV_RD:   state_in = ST_DIV;
         ST_DIV:      state_in = ST_DIV_RUN;
         ST_DIV_RUN:  if (stat.div_done) state_in = ST_EMIT;
         ST_EMIT:     if (!vld_ff || !rsp_stall) begin
            state_in = ST_DIV_RD;
            if (last_key) state_in = ST_LOAD;
         end
         default:     state_in = ST_LOAD;
      endcase
   end

   // outputs and counters
   always_comb begin
      ctrl   = '0;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      vld_in = vld_ff && rsp_stall;
      unique case (state_ff)
         ST_LOAD: begin
            if (acc) begin
               if (!full) begin
                  ctrl.store_score = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ctrl.set_drop = 1'b1;
               end
               idx_in = '0;
            end
         end
         ST_EXP_MUL1: ctrl.exp_start = 1'b1;
         ST_EXP_MUL2: begin
            ctrl.exp_finish = 1'b1;
            idx_in = last_key ? '0 : idx_ff + 1'b1;
         end
         ST_DIV:      ctrl.div_start = 1'b1;
         ST_EMIT: begin
            if (!vld_ff || !rsp_stall) begin
               vld_in = 1'b1;
               ctrl.rsp_load = 1'b1;
               if (last_key) begin
                  ctrl.clear_vec = 1'b1;
                  cnt_in = '0;
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         vld_ff   <= vld_in;
      end
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = vld_ff;
   assign wr_idx    = cnt_ff[IdxW-1:0];
   assign rd_idx    = idx_ff;

   logic last_ff;
   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) last_ff <= last_key;
   end
   assign rsp_out_last = last_ff;

`ifndef SYNTH
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(MaxKeys)) else $error("key count overrun");
   a_load_only: assert property (@(posedge clock) disable iff (reset)
      ctrl.store_score |-> state_ff == ST_LOAD) else $error("store outside load");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result lost");
`endif
endmodule

// ===== design/scaled_softmax.sv =====
// Top level of the scaled softmax block.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | req_score, req_in_last
//  rsp     | out       | rsp_valid/stall   | rsp_weight, rsp_out_last, rsp_overflow
//  csr     | in        | csr_valid/ready   | csr_score_scale
//
// Scores are loaded as requests are accepted. After the last score, the exponent
// pass reads each key's score, forms two table products and adds the result to
// the sum; each weight then goes through an exponent read, a divider start, the
// quotient bits of the divider and a load into the output register.
// Reset is synchronous, active high, and leaves the scale at 1.0.
// A stalled result holds in the output register; no request is taken until
// the last weight of the vector has been loaded into the output register.
module scaled_softmax #(
   parameter int MaxKeys = ssm_pkg::DefaultMaxKeys
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [ssm_pkg::ScoreW-1:0] req_score,
   input  logic                              req_in_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ssm_pkg::WeightW-1:0]       rsp_weight,
   output logic                              rsp_out_last,
   output logic                              rsp_overflow,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ssm_pkg::ScaleW-1:0]        csr_score_scale
);
   import ssm_pkg::*;

   localparam int IdxW = $clog2(MaxKeys);

   ctrl_type          ctrl;
   stat_type          stat;
   logic [IdxW-1:0]   wr_idx, rd_idx;
   logic [ScaleW-1:0] scale_ff;
   logic [WeightW-1:0] weight;
   logic              dropped;
   logic [WeightW-1:0] w_ff;
   logic              ovf_ff;

   // scale register, clamped at 1.0
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ScaleOne;
      end else if (csr_valid && csr_ready) begin
         scale_ff <= (csr_score_scale > ScaleOne) ? ScaleOne : csr_score_scale;
      end
   end
   assign csr_ready = 1'b1;

   ssm_ctrl #(.MaxKeys(MaxKeys)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_in_last  (req_in_last),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_last (rsp_out_last),
      .ctrl         (ctrl),
      .stat         (stat),
      .wr_idx       (wr_idx),
      .rd_idx       (rd_idx)
   );

   ssm_datapath #(.MaxKeys(MaxKeys)) u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .wr_idx  (wr_idx),
      .rd_idx  (rd_idx),
      .score   (req_score),
      .scale   (scale_ff),
      .stat    (stat),
      .weight  (weight),
      .dropped (dropped)
   );

   // output register
   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         w_ff   <= weight;
         ovf_ff <= dropped;
      end
   end
   assign rsp_weight   = w_ff;
   assign rsp_overflow = ovf_ff;

`ifndef SYNTH
   a_scale: assert property (@(posedge clock) disable iff (reset) scale_ff <= ScaleOne)
      else $error("scale above one");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall || rsp_out_last) else $error("request during emit");
   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weight <= WeightW'(65536)) else $error("weight above one");
`endif
endmodule
